// File: sv/rtb_pkg.sv
// ----------------------------------------------------------------------------
// rtb_pkg
// Shared types and constants for the reloadable timer bank: operation codes,
// the layout of one timer entry in the slot RAM and the layout of one result.
// ----------------------------------------------------------------------------
package rtb_pkg;

  // default configuration
  localparam int SLOTS_DEF    = 8;
  localparam int TAG_BITS_DEF = 16;

  // fixed port widths
  localparam int SLOT_W = 6;
  localparam int TAG_W  = 16;
  localparam int CNT_W  = 32;

  // operation codes
  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_ADD        = 3'd1,
    OP_REMOVE     = 3'd2,
    OP_STOP       = 3'd3,
    OP_START      = 3'd4,
    OP_SET_RELOAD = 3'd5
  } op_t;

  // result kinds
  localparam logic KIND_FIRE = 1'b0;
  localparam logic KIND_ADD  = 1'b1;

  // one timer entry as stored in the slot RAM
  typedef struct packed {
    logic             run;
    logic [CNT_W-1:0] reload;
    logic [CNT_W-1:0] count;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // one result item, before the last mark is known
  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
    logic              ok;
  } res_t;

endpackage

// File: sv/reloadable_timer_bank.sv
// ----------------------------------------------------------------------------
// reloadable_timer_bank
// Bank of SLOTS countdown timers with reload. Timer entries live in one slot
// RAM; an occupancy bit per slot sits in flip-flops. A sequencer reads,
// modifies and writes back entries; results leave through rtb_out.
// Operation: tick reads one slot per cycle through the single RAM read port
//   and writes back the slot read before. Add walks one occupancy bit per
//   cycle from slot 0 up to the lowest free slot; stop/start/set reload read
//   the slot, then write it back. Remove and ignored items never leave idle.
// Results appear on the ports one per cycle and cannot be stalled.
// Reset: synchronous; all slots free, no clearing pass needed.
// ----------------------------------------------------------------------------
module reloadable_timer_bank #(
  parameter int SLOTS    = rtb_pkg::SLOTS_DEF,
  parameter int TAG_BITS = rtb_pkg::TAG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  operation,
  input  logic [7:0]  slot,
  input  logic [15:0] handler_tag,
  input  logic [31:0] count,
  input  logic [31:0] reload,
  input  logic        start_running,
  output logic        busy,
  output logic        strobe,
  output logic        kind,
  output logic [5:0]  out_slot,
  output logic [15:0] out_tag,
  output logic        add_ok,
  output logic        last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW = $bits(rtb_pkg::entry_t);
  localparam logic [15:0] TAG_MASK =
    (TAG_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << TAG_BITS) - 32'd1);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_TICK     = 7'b0000010,
    S_ADD_SCAN = 7'b0000100,
    S_ADD_ANS  = 7'b0001000,
    S_SLOT_RD  = 7'b0010000,
    S_SLOT_WB  = 7'b0100000,
    S_FLUSH    = 7'b1000000
  } state_t;

  state_t            state, state_next;
  logic [IW:0]       ctr, ctr_next;
  logic [SLOTS-1:0]  occ, occ_next;
  logic              tick_wb, tick_wb_next;
  logic [IW-1:0]     wb_idx;

  // latched item
  rtb_pkg::op_t      op_q;
  logic [IW-1:0]     slot_q;
  logic [15:0]       tag_q;
  logic [31:0]       cnt_q;
  logic [31:0]       rel_q;
  logic              run_q;

  // ram port signals
  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [EW-1:0]     ram_wdata, ram_rdata;
  rtb_pkg::entry_t   rd_e, wr_e;

  logic              push, flush;
  rtb_pkg::res_t     push_res;

  logic              accept;
  logic              in_range;
  logic [IW-1:0]     idx_in;
  logic [IW-1:0]     ctr_idx;
  logic [31:0]       dec_cnt;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign in_range = {1'b0, slot} < 9'(SLOTS);
  assign idx_in   = slot[IW-1:0];
  assign ctr_idx  = ctr[IW-1:0];
  assign rd_e     = rtb_pkg::entry_t'(ram_rdata);
  assign ram_wdata = EW'(wr_e);
  assign dec_cnt  = rd_e.count - 32'd1;

  // sequencer
  always_comb begin
    state_next   = state;
    ctr_next     = ctr;
    occ_next     = occ;
    tick_wb_next = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = ctr_idx;
    ram_we       = 1'b0;
    ram_waddr    = ctr_idx;
    wr_e         = rd_e;
    push         = 1'b0;
    push_res     = '0;
    flush        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          ctr_next = '0;
          case (operation)
            rtb_pkg::OP_TICK:   state_next = S_TICK;
            rtb_pkg::OP_ADD:    state_next = S_ADD_SCAN;
            rtb_pkg::OP_REMOVE: begin
              if (in_range) begin
                occ_next[idx_in] = 1'b0;
              end
            end
            rtb_pkg::OP_STOP, rtb_pkg::OP_START, rtb_pkg::OP_SET_RELOAD: begin
              if (in_range && occ[idx_in]) begin
                state_next = S_SLOT_RD;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end

      // issue one slot read per cycle, the previous slot is written back below
      S_TICK: begin
        if (ctr != (IW+1)'(SLOTS)) begin
          ram_re       = 1'b1;
          ram_raddr    = ctr_idx;
          ctr_next     = ctr + (IW+1)'(1);
          tick_wb_next = 1'b1;
        end else begin
          state_next = S_FLUSH;
        end
      end

      // walk occupancy bits for the lowest free slot
      S_ADD_SCAN: begin
        if (!occ[ctr_idx]) begin
          ram_we       = 1'b1;
          ram_waddr    = ctr_idx;
          wr_e.run     = run_q;
          wr_e.reload  = rel_q;
          wr_e.tag     = tag_q;
          wr_e.count   = cnt_q;
          occ_next[ctr_idx] = (tag_q != '0);
          if (cnt_q == '0 && tag_q != '0) begin
            push          = 1'b1;
            push_res.kind = rtb_pkg::KIND_FIRE;
            push_res.slot = 6'(ctr_idx);
            push_res.tag  = tag_q;
            if (rel_q != '0) begin
              wr_e.count = rel_q;
            end else begin
              occ_next[ctr_idx] = 1'b0;
            end
          end
          state_next = S_ADD_ANS;
        end else if (ctr == (IW+1)'(SLOTS - 1)) begin
          push          = 1'b1;
          push_res.kind = rtb_pkg::KIND_ADD;
          state_next    = S_FLUSH;
        end else begin
          ctr_next = ctr + (IW+1)'(1);
        end
      end

      S_ADD_ANS: begin
        push          = 1'b1;
        push_res.kind = rtb_pkg::KIND_ADD;
        push_res.slot = 6'(ctr_idx);
        push_res.ok   = 1'b1;
        state_next    = S_FLUSH;
      end

      S_SLOT_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = slot_q;
        state_next = S_SLOT_WB;
      end

      // modify the entry read in the cycle before
      S_SLOT_WB: begin
        ram_we    = 1'b1;
        ram_waddr = slot_q;
        case (op_q)
          rtb_pkg::OP_STOP:  wr_e.run = 1'b0;
          rtb_pkg::OP_START: begin
            wr_e.count = rd_e.reload;
            wr_e.run   = 1'b1;
          end
          rtb_pkg::OP_SET_RELOAD: wr_e.reload = rel_q;
          default: ram_we = 1'b0;
        endcase
        state_next = S_IDLE;
      end

      S_FLUSH: begin
        flush      = 1'b1;
        state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase

    // tick write-back of the slot read in the cycle before
    if (tick_wb && occ[wb_idx] && rd_e.run) begin
      ram_we     = 1'b1;
      ram_waddr  = wb_idx;
      wr_e       = rd_e;
      wr_e.count = dec_cnt;
      if (dec_cnt == '0) begin
        push          = 1'b1;
        push_res.kind = rtb_pkg::KIND_FIRE;
        push_res.slot = 6'(wb_idx);
        push_res.tag  = rd_e.tag;
        if (rd_e.reload != '0) begin
          wr_e.count = rd_e.reload;
        end else begin
          occ_next[wb_idx] = 1'b0;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ctr     <= '0;
      occ     <= '0;
      tick_wb <= 1'b0;
    end else begin
      state   <= state_next;
      ctr     <= ctr_next;
      occ     <= occ_next;
      tick_wb <= tick_wb_next;
    end
  end

  // item and write-back address registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= rtb_pkg::op_t'(operation);
      slot_q <= idx_in;
      tag_q  <= handler_tag & TAG_MASK;
      cnt_q  <= count;
      rel_q  <= reload;
      run_q  <= start_running;
    end
    if (ram_re) begin
      wb_idx <= ram_raddr;
    end
  end

  rtb_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS),
    .AW    (IW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rtb_out u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_res (push_res),
    .flush    (flush),
    .strobe   (strobe),
    .kind     (kind),
    .out_slot (out_slot),
    .out_tag  (out_tag),
    .add_ok   (add_ok),
    .last     (last)
  );

  // an add answer is always the final result of its item
  a_add_last: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == rtb_pkg::KIND_ADD |-> last)
    else $error("add answer without last mark");

  // more results pending means the block is still busy
  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final result while idle");

  // pipelined tick never reads and writes the same slot in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("slot ram read/write collision");

  // occupancy changes only through an accepted or running item
  a_occ_idle: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> $stable(occ))
    else $error("occupancy changed while idle");

endmodule

// File: sv/rtb_ram.sv
// ----------------------------------------------------------------------------
// rtb_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module rtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/rtb_out.sv
// ----------------------------------------------------------------------------
// rtb_out
// Result stage: holds back the newest result by one push so that the final
// result of an item can carry the last mark, then drives the result ports.
// ----------------------------------------------------------------------------
module rtb_out (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rtb_pkg::res_t        push_res,
  input  logic                 flush,
  output logic                 strobe,
  output logic                 kind,
  output logic [5:0]           out_slot,
  output logic [15:0]          out_tag,
  output logic                 add_ok,
  output logic                 last
);

  rtb_pkg::res_t hold;
  logic          hold_vld;
  logic          emit;
  logic          emit_last;

  // a push releases the held result, a flush releases it as the last one
  always_comb begin
    emit      = hold_vld && (push || flush);
    emit_last = !push && flush;
  end

  // hold register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
    end else if (push) begin
      hold_vld <= 1'b1;
    end else if (flush) begin
      hold_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      hold <= push_res;
    end
  end

  // result port registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind     <= hold.kind;
      out_slot <= hold.slot;
      out_tag  <= hold.tag;
      add_ok   <= hold.ok;
      last     <= emit_last;
    end
  end

endmodule
